// ===== hdl/h264_rtp_depacketizer_assert.svh =====
// Assertion macros shared by the depacketizer RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef H264_RTP_DEPACKETIZER_ASSERT_SVH
`define H264_RTP_DEPACKETIZER_ASSERT_SVH

// Same-cycle implication.
`define H264D_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define H264D_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/h264d_pkg.sv =====
// Package for the H.264 RTP depacketizer: constants, status codes, command
// and result types. No dependencies.
`default_nettype none

package h264d_pkg;

   localparam logic [4:0] TYPE_SINGLE_LO = 5'd1;
   localparam logic [4:0] TYPE_SINGLE_HI = 5'd12;
   localparam logic [4:0] TYPE_STAP_A    = 5'd24;
   localparam logic [4:0] TYPE_FU_A      = 5'd28;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_UNSUP     = 3'd1;
   localparam logic [2:0] STATUS_NO_START  = 3'd2;
   localparam logic [2:0] STATUS_START_END = 3'd3;
   localparam logic [2:0] STATUS_BAD_LEN   = 3'd4;

   // Start code 00 00 00 01 followed by the NAL header byte.
   localparam logic [2:0] STEP_LAST_ZERO = 3'd2;
   localparam logic [2:0] STEP_ONE       = 3'd3;
   localparam logic [2:0] STEP_HDR       = 3'd4;

   typedef struct packed {
      logic [7:0] data;
      logic       emit;
      logic       with_start;
      logic       done;
      logic [2:0] status;
   } cmd_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       nal_begin;
      logic       packet_done;
      logic [2:0] packet_status;
      logic       last_of_run;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== hdl/h264d_req_if.sv =====
// Input channel: one RTP payload byte per transfer with packet markers.
// No dependencies.
`default_nettype none

interface h264d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;
   logic       last_byte;

   modport source(output valid, data_byte, first_byte, last_byte, input ready);
   modport sink(input valid, data_byte, first_byte, last_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/h264d_rsp_if.sv =====
// Result channel: one Annex B stream byte or status item per transfer.
// No dependencies.
`default_nettype none

interface h264d_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       nal_begin;
   logic       packet_done;
   logic [2:0] packet_status;
   logic       last_of_run;

   modport source(output valid, out_byte, byte_valid, nal_begin, packet_done,
                  packet_status, last_of_run, input ready);
   modport sink(input valid, out_byte, byte_valid, nal_begin, packet_done,
                packet_status, last_of_run, output ready);
endinterface

`default_nettype wire

// ===== hdl/h264d_front.sv =====
// Front end: accepts payload bytes, tracks packet parsing state and issues
// one command per byte that produces output. Uses h264d_pkg, h264d_req_if.
`default_nettype none

module h264d_front
   import h264d_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   h264d_req_if.sink   req,
   input  wire logic   q_full,
   output logic        q_push,
   output cmd_type     q_cmd
);

   localparam logic [2:0] M_IDLE      = 3'd0;
   localparam logic [2:0] M_COPY      = 3'd1;
   localparam logic [2:0] M_LEN_HI    = 3'd2;
   localparam logic [2:0] M_LEN_LO    = 3'd3;
   localparam logic [2:0] M_UNIT_HDR  = 3'd4;
   localparam logic [2:0] M_UNIT_BODY = 3'd5;
   localparam logic [2:0] M_FU_HDR    = 3'd6;
   localparam logic [2:0] M_DROP      = 3'd7;

   logic [2:0]  mode_ff, mode_in;
   logic [15:0] left_ff, left_in;
   logic [7:0]  len_hi_ff, len_hi_in;
   logic [2:0]  ind_ff, ind_in;
   logic        frag_ff, frag_in;
   logic [2:0]  err_ff, err_in;

   logic        accept;
   logic [4:0]  nal_type;
   logic [15:0] left_dec;
   cmd_type     cmd;

   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;
   assign nal_type  = req.data_byte[4:0];
   assign left_dec  = left_ff - 16'd1;

   always_comb begin
      mode_in   = mode_ff;
      left_in   = left_ff;
      len_hi_in = len_hi_ff;
      ind_in    = ind_ff;
      frag_in   = frag_ff;
      err_in    = err_ff;
      cmd.data       = req.data_byte;
      cmd.emit       = 1'b0;
      cmd.with_start = 1'b0;
      cmd.done       = 1'b0;
      cmd.status     = STATUS_OK;

      if (req.first_byte) begin
         err_in = STATUS_OK;
         if (nal_type >= TYPE_SINGLE_LO && nal_type <= TYPE_SINGLE_HI) begin
            cmd.emit       = 1'b1;
            cmd.with_start = 1'b1;
            mode_in        = M_COPY;
         end else if (nal_type == TYPE_STAP_A) begin
            mode_in = M_LEN_HI;
         end else if (nal_type == TYPE_FU_A) begin
            ind_in  = req.data_byte[7:5];
            mode_in = M_FU_HDR;
         end else begin
            err_in  = STATUS_UNSUP;
            mode_in = M_DROP;
         end
      end else begin
         unique case (mode_ff)
            M_COPY: begin
               cmd.emit = 1'b1;
            end
            M_LEN_HI: begin
               len_hi_in = req.data_byte;
               mode_in   = M_LEN_LO;
            end
            M_LEN_LO: begin
               left_in = {len_hi_ff, req.data_byte};
               if ({len_hi_ff, req.data_byte} == 16'd0) begin
                  err_in  = STATUS_BAD_LEN;
                  mode_in = M_DROP;
               end else begin
                  mode_in = M_UNIT_HDR;
               end
            end
            M_UNIT_HDR, M_UNIT_BODY: begin
               cmd.emit       = 1'b1;
               cmd.with_start = (mode_ff == M_UNIT_HDR);
               left_in        = left_dec;
               mode_in        = (left_dec == 16'd0) ? M_LEN_HI : M_UNIT_BODY;
            end
            M_FU_HDR: begin
               priority if (req.data_byte[7] && req.data_byte[6]) begin
                  frag_in = 1'b0;
                  err_in  = STATUS_START_END;
                  mode_in = M_DROP;
               end else if (req.data_byte[7]) begin
                  if (frag_ff) begin
                     mode_in = M_DROP;
                  end else begin
                     frag_in        = 1'b1;
                     cmd.emit       = 1'b1;
                     cmd.with_start = 1'b1;
                     cmd.data       = {ind_ff, req.data_byte[4:0]};
                     mode_in        = M_COPY;
                  end
               end else if (frag_ff) begin
                  if (req.data_byte[6]) begin
                     frag_in = 1'b0;
                  end
                  mode_in = M_COPY;
               end else begin
                  err_in  = STATUS_NO_START;
                  mode_in = M_DROP;
               end
            end
            default: begin
            end
         endcase
      end

      if (req.last_byte && mode_in != M_IDLE) begin
         if (err_in == STATUS_OK && (mode_in == M_LEN_LO || mode_in == M_UNIT_HDR ||
                                     mode_in == M_UNIT_BODY || mode_in == M_FU_HDR)) begin
            err_in = STATUS_BAD_LEN;
         end
         cmd.done   = 1'b1;
         cmd.status = err_in;
         mode_in    = M_IDLE;
         err_in     = STATUS_OK;
      end
   end

   assign q_push = accept && (cmd.emit || cmd.done);
   assign q_cmd  = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_IDLE;
         left_ff   <= 16'd0;
         len_hi_ff <= 8'd0;
         ind_ff    <= 3'd0;
         frag_ff   <= 1'b0;
         err_ff    <= STATUS_OK;
      end else if (accept) begin
         mode_ff   <= mode_in;
         left_ff   <= left_in;
         len_hi_ff <= len_hi_in;
         ind_ff    <= ind_in;
         frag_ff   <= frag_in;
         err_ff    <= err_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/h264d_fifo.sv =====
// Command queue between front end and output sequencer.
// Uses h264d_pkg and the assertion macro header.
`default_nettype none
`include "h264_rtp_depacketizer_assert.svh"

module h264d_fifo
   import h264d_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output cmd_type      head,
   output logic         empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `H264D_ASSERT_IMP(a_no_overflow, clock, reset, push, !full, "push into full queue")
   `H264D_ASSERT_IMP(a_no_underflow, clock, reset, pop, !empty, "pop from empty queue")
   `H264D_ASSERT_NXT(a_count_up, clock, reset, push && !pop,
                     count_ff == $past(count_ff) + 1'b1, "count did not advance")

endmodule

`default_nettype wire

// ===== hdl/h264d_back.sv =====
// Output sequencer: expands queued commands into result transfers, adding
// the start code where needed. Uses h264d_pkg, h264d_rsp_if, assertion macros.
`default_nettype none
`include "h264_rtp_depacketizer_assert.svh"

module h264d_back
   import h264d_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd,
   input  wire logic    cmd_valid,
   output logic         cmd_pop,
   h264d_rsp_if.source  rsp
);

   logic [2:0]   step_ff, step_in;
   logic         rsp_valid_ff;
   rsp_item_type item_ff, item_in;
   logic         out_free;
   logic         fire;
   logic         final_item;

   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign fire       = cmd_valid && out_free;
   assign final_item = !cmd.with_start || (step_ff == STEP_HDR);
   assign cmd_pop    = fire && final_item;
   assign step_in    = final_item ? 3'd0 : step_ff + 3'd1;

   always_comb begin
      item_in.out_byte = cmd.data;
      if (cmd.with_start && step_ff <= STEP_LAST_ZERO) begin
         item_in.out_byte = 8'h00;
      end else if (cmd.with_start && step_ff == STEP_ONE) begin
         item_in.out_byte = 8'h01;
      end else if (!cmd.emit) begin
         item_in.out_byte = 8'h00;
      end
      item_in.byte_valid    = cmd.emit;
      item_in.nal_begin     = cmd.with_start && (step_ff == 3'd0);
      item_in.packet_done   = final_item && cmd.done;
      item_in.packet_status = (final_item && cmd.done) ? cmd.status : STATUS_OK;
      item_in.last_of_run   = final_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            step_ff      <= step_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         item_ff <= item_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.out_byte      = item_ff.out_byte;
   assign rsp.byte_valid    = item_ff.byte_valid;
   assign rsp.nal_begin     = item_ff.nal_begin;
   assign rsp.packet_done   = item_ff.packet_done;
   assign rsp.packet_status = item_ff.packet_status;
   assign rsp.last_of_run   = item_ff.last_of_run;

   `H264D_ASSERT_IMP(a_step_has_cmd, clock, reset, step_ff != 3'd0,
                     cmd_valid && cmd.with_start, "start sequence without command")
   `H264D_ASSERT_IMP(a_done_is_last, clock, reset, rsp_valid_ff && item_ff.packet_done,
                     item_ff.last_of_run, "packet close not last of run")
   `H264D_ASSERT_IMP(a_step_range, clock, reset, 1'b1, step_ff <= STEP_HDR,
                     "step counter out of range")

endmodule

`default_nettype wire

// ===== hdl/h264_rtp_depacketizer.sv =====
// H.264 RTP depacketizer (single NAL, STAP-A, FU-A) producing Annex B bytes.
// One payload byte is taken per cycle while the command queue has room. A
// byte that opens a NAL unit yields five results (00 00 00 01 and header),
// other bytes yield one or none; the output register delivers one result
// per cycle while the receiver is ready, so copied data sustains one input
// byte per cycle, and a start-code byte holds the output for five results;
// QUEUE_DEPTH commands of slack lie between the parser and the output
// sequencer. A byte's results pass through the command queue and then the
// output register. Uses h264d_pkg, h264d_req_if, h264d_rsp_if, h264d_front,
// h264d_fifo, h264d_back.
`default_nettype none

module h264_rtp_depacketizer
   import h264d_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic   clock,
   input  wire logic   reset,
   h264d_req_if.sink   req_ch,
   h264d_rsp_if.source rsp_ch
);

   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_empty;
   cmd_type q_in;
   cmd_type q_head;

   h264d_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_cmd  (q_in)
   );

   h264d_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_in),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   h264d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (q_head),
      .cmd_valid (!q_empty),
      .cmd_pop   (q_pop),
      .rsp       (rsp_ch)
   );

endmodule

`default_nettype wire
